// ===== sv/assert_macros.svh =====
// Assertion helpers: implication in the same cycle and in the next cycle.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);

`define ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rstn, cond, prop, msg)

`define ASSERT_NEXT(label, clk, rstn, cond, prop, msg)

`endif

`endif

// ===== sv/ovpr_pkg.sv =====
package ovpr_pkg;

    localparam int PCT_BITS     = 7;
    localparam int CFG_IDX_BITS = 3;
    localparam int PERCENT_FULL = 100;

    localparam int CTRL_MIN_RESET = 0;
    localparam int CTRL_MAX_RESET = 1000000;
    localparam int OUT_MIN_RESET  = 0;
    localparam int OUT_MAX_RESET  = 1000000;
    localparam int PCT_RESET      = 0;
    localparam int SLEW_RESET     = 1;

    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_CTRL_MIN = 3'd0;
    localparam cfg_idx_t REG_CTRL_MAX = 3'd1;
    localparam cfg_idx_t REG_OUT_MIN  = 3'd2;
    localparam cfg_idx_t REG_OUT_MAX  = 3'd3;
    localparam cfg_idx_t REG_OVP_PCT  = 3'd4;
    localparam cfg_idx_t REG_SLEW     = 3'd5;

    localparam logic KIND_REQ   = 1'b0;
    localparam logic KIND_ACK   = 1'b1;
    localparam logic CMD_DRIVE  = 1'b0;
    localparam logic CMD_DONE   = 1'b1;
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SINGLE,
        PH_STEP,
        PH_RESTORE
    } phase_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_DECODE,
        SQ_START,
        SQ_RUN,
        SQ_EMIT
    } seq_state_t;

    typedef enum logic [2:0] {
        OP_C2O,
        OP_LO,
        OP_HI,
        OP_DROP,
        OP_WAIT,
        OP_NEXT
    } op_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_ADD,
        MD_DIV
    } md_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } md_stat_t;

endpackage

// ===== sv/ovpr_muldiv.sv =====
`include "assert_macros.svh"

module ovpr_muldiv #(
    parameter int VOLT_BITS = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [VOLT_BITS-1:0] a,
    input  logic [VOLT_BITS-1:0] b,
    input  logic [VOLT_BITS-1:0] c,
    input  logic [VOLT_BITS-1:0] d,
    output logic [VOLT_BITS:0]   q,
    output ovpr_pkg::md_stat_t   stat
);
    import ovpr_pkg::*;

    localparam int PW       = 2 * VOLT_BITS;
    localparam int CNT_BITS = $clog2(VOLT_BITS + 1);

    md_state_t st_reg, st_next;
    logic done_reg, done_next;

    logic [PW-1:0]        prod_reg;
    logic [VOLT_BITS-1:0] c_reg;
    logic [VOLT_BITS-1:0] d_reg;
    logic [VOLT_BITS-1:0] rem_reg;
    logic [VOLT_BITS:0]   dq_reg;
    logic [CNT_BITS-1:0]  cnt_reg;

    logic [PW-1:0]      prod;
    logic [PW-1:0]      sum;
    logic [VOLT_BITS:0] trial;
    logic [VOLT_BITS:0] diffv;
    logic               fits;
    logic               last;

    assign prod  = {{VOLT_BITS{1'b0}}, a} * {{VOLT_BITS{1'b0}}, b};
    assign sum   = prod_reg + {{VOLT_BITS{1'b0}}, c_reg};
    assign trial = {rem_reg, dq_reg[VOLT_BITS]};
    assign fits  = trial >= {1'b0, d_reg};
    assign diffv = trial - {1'b0, d_reg};
    assign last  = cnt_reg == CNT_BITS'(VOLT_BITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= MD_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_comb begin
        st_next   = st_reg;
        done_next = 1'b0;
        unique case (st_reg)
            MD_IDLE: begin
                if (start) begin
                    st_next = MD_ADD;
                end
            end
            MD_ADD: begin
                st_next = MD_DIV;
            end
            MD_DIV: begin
                if (last) begin
                    st_next   = MD_IDLE;
                    done_next = 1'b1;
                end
            end
            default: begin
                st_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        case (st_reg)
            MD_IDLE: begin
                if (start) begin
                    prod_reg <= prod;
                    c_reg    <= c;
                    d_reg    <= d;
                end
            end
            MD_ADD: begin
                rem_reg <= {1'b0, sum[PW-1:VOLT_BITS+1]};
                dq_reg  <= sum[VOLT_BITS:0];
                cnt_reg <= '0;
            end
            MD_DIV: begin
                dq_reg  <= {dq_reg[VOLT_BITS-1:0], fits};
                rem_reg <= fits ? diffv[VOLT_BITS-1:0] : trial[VOLT_BITS-1:0];
                cnt_reg <= cnt_reg + CNT_BITS'(1);
            end
            default: begin
            end
        endcase
    end

    assign q         = dq_reg;
    assign stat.busy = st_reg != MD_IDLE;
    assign stat.done = done_reg;

    `ASSERT_NEXT(a_done_pulse, aclk, aresetn, done_reg, !done_reg, "done held over two cycles")
    `ASSERT_NEXT(a_start_busy, aclk, aresetn, start, stat.busy, "start did not take")

endmodule

// ===== sv/ovp_safe_voltage_ramp_linear_unit.sv =====
// Request: up to four passes through the shared multiply-divide unit, each
// made of one multiply, one add, VOLT_BITS+1 divide steps and a hand-back.
// Acknowledge: no pass, or three passes for the next step.
// One request at a time; the result register lets the next request in early.
// Reset: synchronous, active low; registers to defaults, sequence idle.
`include "assert_macros.svh"

module ovp_safe_voltage_ramp_linear_unit #(
    parameter int VOLT_BITS = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  ovpr_pkg::cfg_idx_t    cfg_index,
    input  logic [VOLT_BITS-1:0]  cfg_data,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // req_min_uv, req_max_uv, ctrl_readback_uv, ack_ok, zero fill
    input  logic [((3*VOLT_BITS+8)/8)*8-1:0] s_tdata,
    // kind
    input  logic                  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // ctrl_low_uv, ctrl_high_uv, wait_us, status, zero fill
    output logic [((3*VOLT_BITS+8)/8)*8-1:0] m_tdata,
    // command
    output logic                  m_tuser
);
    import ovpr_pkg::*;

    localparam int W  = VOLT_BITS;
    localparam int DW = ((3 * VOLT_BITS + 8) / 8) * 8;

    function automatic logic [VOLT_BITS-1:0] clamp_v(input logic [VOLT_BITS-1:0] lo,
                                                    input logic [VOLT_BITS-1:0] hi,
                                                    input logic [VOLT_BITS-1:0] v);
        logic [VOLT_BITS-1:0] r;
        r = v;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

    logic [W-1:0]        ctrl_min_reg, ctrl_max_reg, out_min_reg, out_max_reg, slew_reg;
    logic [PCT_BITS-1:0] pct_reg;

    seq_state_t st_reg, st_next;
    phase_t     phase_reg, phase_next;
    op_t        op_reg, op_next;

    logic         kind_reg, ok_reg;
    logic [W-1:0] in_min_reg, in_max_reg, in_rb_reg;
    logic [W-1:0] present_reg, floor_reg, pending_reg, original_reg;
    logic [W-1:0] lo_res_reg, hi_res_reg, wait_res_reg;
    logic         cmd_res_reg, status_res_reg;

    logic          m_tvalid_reg;
    logic [DW-1:0] m_tdata_reg;
    logic          m_tuser_reg;

    logic [W-1:0] cmax, omax, cspan, ospan, slew_eff;
    logic [W-1:0] ov_sel, off_raw, off;
    logic [W-1:0] md_a, md_b, md_c, md_d;
    logic [W:0]   md_q;
    md_stat_t     md_stat;
    logic         md_start;

    logic [W-1:0] qv, now_v, ctrl_v, diff_v, next_v;
    logic [W:0]   drop_v;
    logic         single_v, more_steps, m_free, s_acc;

    assign cmax     = (ctrl_max_reg < ctrl_min_reg) ? ctrl_min_reg : ctrl_max_reg;
    assign omax     = (out_max_reg < out_min_reg) ? out_min_reg : out_max_reg;
    assign cspan    = cmax - ctrl_min_reg;
    assign ospan    = omax - out_min_reg;
    assign slew_eff = (slew_reg == '0) ? W'(1) : slew_reg;

    assign s_tready = st_reg == SQ_IDLE;
    assign s_acc    = s_tvalid && s_tready;
    assign m_free   = !m_tvalid_reg || m_tready;
    assign md_start = st_reg == SQ_START;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_min_reg <= W'(CTRL_MIN_RESET);
            ctrl_max_reg <= W'(CTRL_MAX_RESET);
            out_min_reg  <= W'(OUT_MIN_RESET);
            out_max_reg  <= W'(OUT_MAX_RESET);
            pct_reg      <= PCT_BITS'(PCT_RESET);
            slew_reg     <= W'(SLEW_RESET);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CTRL_MIN: ctrl_min_reg <= cfg_data;
                REG_CTRL_MAX: ctrl_max_reg <= cfg_data;
                REG_OUT_MIN:  out_min_reg  <= cfg_data;
                REG_OUT_MAX:  out_max_reg  <= cfg_data;
                REG_OVP_PCT:  pct_reg      <= cfg_data[PCT_BITS-1:0];
                REG_SLEW:     slew_reg     <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (op_reg)
            OP_LO:   ov_sel = in_min_reg;
            OP_HI:   ov_sel = in_max_reg;
            default: ov_sel = pending_reg;
        endcase
        off_raw = (ov_sel > out_min_reg) ? ov_sel - out_min_reg : '0;
        off     = (off_raw > ospan) ? ospan : off_raw;
    end

    always_comb begin
        md_a = '0;
        md_b = '0;
        md_c = '0;
        md_d = '0;
        case (op_reg) inside
            OP_C2O: begin
                md_a = in_rb_reg - ctrl_min_reg;
                md_b = ospan;
                md_c = cspan >> 1;
                md_d = cspan;
            end
            OP_LO, OP_HI, OP_NEXT: begin
                md_a = off;
                md_b = cspan;
                md_c = ospan >> 1;
                md_d = ospan;
            end
            OP_DROP: begin
                md_a = present_reg;
                md_b = {{(W-PCT_BITS){1'b0}}, pct_reg};
                md_c = '0;
                md_d = W'(PERCENT_FULL);
            end
            OP_WAIT: begin
                md_a = present_reg - pending_reg;
                md_b = W'(1);
                md_c = slew_eff - W'(1);
                md_d = slew_eff;
            end
            default: begin
            end
        endcase
    end

    ovpr_muldiv #(
        .VOLT_BITS(VOLT_BITS)
    ) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (md_start),
        .a       (md_a),
        .b       (md_b),
        .c       (md_c),
        .d       (md_d),
        .q       (md_q),
        .stat    (md_stat)
    );

    always_comb begin
        qv = md_q[W-1:0];
        if (in_rb_reg < ctrl_min_reg) begin
            now_v = out_min_reg;
        end else if (in_rb_reg > cmax) begin
            now_v = omax;
        end else if (cspan == '0) begin
            now_v = out_min_reg;
        end else begin
            now_v = out_min_reg + qv;
        end
        ctrl_v     = (ospan == '0) ? ctrl_min_reg : ctrl_min_reg + qv;
        drop_v     = (md_q == '0) ? (W+1)'(1) : md_q;
        diff_v     = present_reg - floor_reg;
        next_v     = (drop_v >= {1'b0, diff_v}) ? floor_reg : present_reg - drop_v[W-1:0];
        single_v   = (in_min_reg >= now_v) || (pct_reg == '0);
        more_steps = pending_reg > floor_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= SQ_IDLE;
            phase_reg    <= PH_IDLE;
            op_reg       <= OP_C2O;
            m_tvalid_reg <= 1'b0;
        end else begin
            st_reg    <= st_next;
            phase_reg <= phase_next;
            op_reg    <= op_next;
            if (st_reg == SQ_EMIT && m_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        st_next    = st_reg;
        phase_next = phase_reg;
        op_next    = op_reg;
        unique case (st_reg)
            SQ_IDLE: begin
                if (s_tvalid) begin
                    st_next = SQ_DECODE;
                end
            end
            SQ_DECODE: begin
                if (kind_reg == KIND_ACK) begin
                    case (phase_reg) inside
                        PH_SINGLE, PH_RESTORE: begin
                            phase_next = PH_IDLE;
                            st_next    = SQ_EMIT;
                        end
                        PH_STEP: begin
                            if (!ok_reg) begin
                                phase_next = PH_RESTORE;
                                st_next    = SQ_EMIT;
                            end else if (more_steps) begin
                                op_next = OP_DROP;
                                st_next = SQ_START;
                            end else begin
                                phase_next = PH_IDLE;
                                st_next    = SQ_EMIT;
                            end
                        end
                        default: begin
                            st_next = SQ_IDLE;
                        end
                    endcase
                end else if (phase_reg == PH_IDLE) begin
                    op_next = OP_C2O;
                    st_next = SQ_START;
                end else begin
                    st_next = SQ_IDLE;
                end
            end
            SQ_START: begin
                st_next = SQ_RUN;
            end
            SQ_RUN: begin
                if (md_stat.done) begin
                    st_next = SQ_START;
                    case (op_reg) inside
                        OP_C2O: begin
                            if (single_v) begin
                                phase_next = PH_SINGLE;
                                op_next    = OP_LO;
                            end else begin
                                phase_next = PH_STEP;
                                op_next    = OP_DROP;
                            end
                        end
                        OP_LO:   op_next = OP_HI;
                        OP_DROP: op_next = OP_WAIT;
                        OP_WAIT: op_next = OP_NEXT;
                        OP_HI, OP_NEXT: st_next = SQ_EMIT;
                        default: st_next = SQ_IDLE;
                    endcase
                end
            end
            SQ_EMIT: begin
                if (m_free) begin
                    st_next = SQ_IDLE;
                end
            end
            default: begin
                st_next = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            kind_reg   <= s_tuser;
            ok_reg     <= s_tdata[3*W];
            in_min_reg <= clamp_v(out_min_reg, omax, s_tdata[W-1:0]);
            in_max_reg <= clamp_v(out_min_reg, omax, s_tdata[2*W-1:W]);
            in_rb_reg  <= s_tdata[3*W-1:2*W];
        end
        case (st_reg)
            SQ_DECODE: begin
                wait_res_reg <= '0;
                if ((kind_reg == KIND_ACK) && (phase_reg == PH_STEP) && !ok_reg) begin
                    cmd_res_reg <= CMD_DRIVE;
                    lo_res_reg  <= original_reg;
                    hi_res_reg  <= original_reg;
                end else begin
                    cmd_res_reg <= CMD_DONE;
                    lo_res_reg  <= '0;
                    hi_res_reg  <= '0;
                end
                if ((kind_reg == KIND_ACK) && ((phase_reg == PH_RESTORE) ||
                        ((phase_reg == PH_SINGLE) && !ok_reg))) begin
                    status_res_reg <= STATUS_ERR;
                end else begin
                    status_res_reg <= STATUS_OK;
                end
                if ((kind_reg == KIND_ACK) && (phase_reg == PH_STEP) && ok_reg) begin
                    present_reg <= pending_reg;
                end
                if ((kind_reg == KIND_REQ) && (phase_reg == PH_IDLE)) begin
                    original_reg <= in_rb_reg;
                end
            end
            SQ_RUN: begin
                if (md_stat.done) begin
                    case (op_reg)
                        OP_C2O: begin
                            present_reg <= now_v;
                            floor_reg   <= in_min_reg;
                        end
                        OP_LO: lo_res_reg <= ctrl_v;
                        OP_HI: begin
                            hi_res_reg     <= ctrl_v;
                            wait_res_reg   <= '0;
                            cmd_res_reg    <= CMD_DRIVE;
                            status_res_reg <= STATUS_OK;
                        end
                        OP_DROP: pending_reg <= next_v;
                        OP_WAIT: wait_res_reg <= qv;
                        OP_NEXT: begin
                            lo_res_reg     <= ctrl_v;
                            hi_res_reg     <= ctrl_v;
                            cmd_res_reg    <= CMD_DRIVE;
                            status_res_reg <= STATUS_OK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            SQ_EMIT: begin
                if (m_free) begin
                    m_tdata_reg <= DW'({status_res_reg, wait_res_reg, hi_res_reg, lo_res_reg});
                    m_tuser_reg <= cmd_res_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `ASSERT_IMPLIES(a_start_free, aclk, aresetn, st_reg == SQ_START, !md_stat.busy, "unit started while busy")
    `ASSERT_IMPLIES(a_done_in_run, aclk, aresetn, md_stat.done, st_reg == SQ_RUN, "unit result not awaited")
    `ASSERT_IMPLIES(a_step_floor, aclk, aresetn, (phase_reg == PH_STEP) && (st_reg == SQ_IDLE), pending_reg >= floor_reg, "step below floor")

endmodule

// ===== tb/tb_ovp_safe_voltage_ramp_linear_unit.sv =====
`timescale 1ns / 1ps

module tb_ovp_safe_voltage_ramp_linear_unit;
    import ovpr_pkg::*;

    localparam int VB = 24;
    localparam int DW = ((3*VB+8)/8)*8;
    localparam logic [VB-1:0] VMAX = {VB{1'b1}};
    localparam int RANDOM_ITEMS = 700;
    localparam int NUM_SETTINGS = 8;
    localparam int SETTLE_CYCLES = 150;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic          kind;
        logic [VB-1:0] rmin;
        logic [VB-1:0] rmax;
        logic [VB-1:0] rb;
        logic          ok;
    } ramp_req_t;

    typedef struct packed {
        logic          command;
        logic [VB-1:0] lo;
        logic [VB-1:0] hi;
        logic [VB-1:0] wait_us;
        logic          status;
    } ramp_cmd_t;

    typedef struct {
        logic          is_cfg;
        cfg_idx_t      idx;
        logic [VB-1:0] val;
        ramp_req_t     req;
        logic          typed;
        ramp_cmd_t     want;
    } plan_row_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          cfg_wr_en = 1'b0;
    cfg_idx_t      cfg_index = REG_CTRL_MIN;
    logic [VB-1:0] cfg_data = '0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic          s_tuser = KIND_REQ;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [DW-1:0] m_tdata;
    logic          m_tuser;

    // register copy
    logic [VB-1:0]       c_min = VB'(CTRL_MIN_RESET);
    logic [VB-1:0]       c_max = VB'(CTRL_MAX_RESET);
    logic [VB-1:0]       o_min = VB'(OUT_MIN_RESET);
    logic [VB-1:0]       o_max = VB'(OUT_MAX_RESET);
    logic [PCT_BITS-1:0] pct = PCT_BITS'(PCT_RESET);
    logic [VB-1:0]       slew = VB'(SLEW_RESET);

    // sequencer copy
    phase_t        ph = PH_IDLE;
    logic [VB-1:0] pres = '0;
    logic [VB-1:0] floor_uv = '0;
    logic [VB-1:0] pend = '0;
    logic [VB-1:0] orig = '0;
    logic          failed = 1'b0;

    ramp_cmd_t pending_cmds[$];
    plan_row_t ramp_plan[$];

    bit idle_on = 1'b1;
    bit dirty = 1'b0;
    int mismatches = 0;
    int n_drive = 0;
    int n_done_ok = 0;
    int n_done_err = 0;
    int n_items = 0;
    int n_cfg = 0;

    ovp_safe_voltage_ramp_linear_unit #(
        .VOLT_BITS(VB)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("FAIL ovp_safe_voltage_ramp_linear_unit");
        $finish;
    end

    function automatic logic [VB-1:0] top_of(logic [VB-1:0] lo, logic [VB-1:0] hi);
        return (hi < lo) ? lo : hi;
    endfunction

    function automatic logic [VB-1:0] out_of_ctrl(logic [VB-1:0] rb);
        logic [VB-1:0] ctop, otop, cspan;
        logic [63:0]   num;
        ctop = top_of(c_min, c_max);
        otop = top_of(o_min, o_max);
        cspan = ctop - c_min;
        if (rb < c_min) return o_min;
        if (rb > ctop) return otop;
        if (cspan == '0) return o_min;
        num = 64'(rb - c_min) * 64'(otop - o_min);
        return VB'(64'(o_min) + (num + 64'(cspan / 2)) / 64'(cspan));
    endfunction

    function automatic logic [VB-1:0] ctrl_of_out(logic [VB-1:0] ov);
        logic [VB-1:0] ctop, otop, ospan, off;
        logic [63:0]   num;
        ctop = top_of(c_min, c_max);
        otop = top_of(o_min, o_max);
        ospan = otop - o_min;
        off = (ov > o_min) ? ov - o_min : '0;
        if (ospan == '0) return c_min;
        if (off > ospan) off = ospan;
        num = 64'(off) * 64'(ctop - c_min);
        return VB'(64'(c_min) + (num + 64'(ospan / 2)) / 64'(ospan));
    endfunction

    function automatic logic [VB-1:0] clamp_to_out(logic [VB-1:0] v);
        logic [VB-1:0] otop;
        otop = top_of(o_min, o_max);
        if (v < o_min) return o_min;
        if (v > otop) return otop;
        return v;
    endfunction

    function automatic ramp_cmd_t mk_cmd(logic command, logic [VB-1:0] lo, logic [VB-1:0] hi,
                                         logic [VB-1:0] w, logic status);
        return '{command, lo, hi, w, status};
    endfunction

    function automatic ramp_req_t mk_req(logic [VB-1:0] rmin, logic [VB-1:0] rmax,
                                         logic [VB-1:0] rb);
        return '{KIND_REQ, rmin, rmax, rb, 1'b0};
    endfunction

    function automatic ramp_req_t mk_ack(logic ok);
        return '{KIND_ACK, '0, '0, '0, ok};
    endfunction

    function automatic ramp_cmd_t plan_step();
        logic [VB-1:0] s, diff, nxt, fall, c;
        logic [63:0]   drop, w;
        s = (slew == '0) ? VB'(1) : slew;
        drop = (64'(pres) * 64'(pct)) / 64'(PERCENT_FULL);
        diff = pres - floor_uv;
        if (drop == 64'd0) drop = 64'd1;
        nxt = (drop >= 64'(diff)) ? floor_uv : pres - VB'(drop);
        fall = pres - nxt;
        w = (64'(fall) + 64'(s) - 64'd1) / 64'(s);
        pend = nxt;
        c = ctrl_of_out(nxt);
        return mk_cmd(CMD_DRIVE, c, c, VB'(w), STATUS_OK);
    endfunction

    function automatic bit ramp_predict(input ramp_req_t r, output ramp_cmd_t res);
        logic [VB-1:0] lo_out, hi_out, now;
        res = '0;
        if (r.kind == KIND_REQ) begin
            if (ph != PH_IDLE) return 1'b0;
            lo_out = clamp_to_out(r.rmin);
            hi_out = clamp_to_out(r.rmax);
            now = out_of_ctrl(r.rb);
            failed = 1'b0;
            orig = r.rb;
            if (lo_out >= now || pct == '0) begin
                ph = PH_SINGLE;
                res = mk_cmd(CMD_DRIVE, ctrl_of_out(lo_out), ctrl_of_out(hi_out), '0, STATUS_OK);
                return 1'b1;
            end
            pres = now;
            floor_uv = lo_out;
            ph = PH_STEP;
            res = plan_step();
            return 1'b1;
        end
        case (ph)
            PH_SINGLE: begin
                ph = PH_IDLE;
                failed = !r.ok;
                res = mk_cmd(CMD_DONE, '0, '0, '0, r.ok ? STATUS_OK : STATUS_ERR);
                return 1'b1;
            end
            PH_STEP: begin
                if (!r.ok) begin
                    failed = 1'b1;
                    ph = PH_RESTORE;
                    res = mk_cmd(CMD_DRIVE, orig, orig, '0, STATUS_OK);
                    return 1'b1;
                end
                pres = pend;
                if (pres > floor_uv) begin
                    res = plan_step();
                    return 1'b1;
                end
                ph = PH_IDLE;
                res = mk_cmd(CMD_DONE, '0, '0, '0, STATUS_OK);
                return 1'b1;
            end
            PH_RESTORE: begin
                ph = PH_IDLE;
                failed = 1'b1;
                res = mk_cmd(CMD_DONE, '0, '0, '0, STATUS_ERR);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic void apply_reg(cfg_idx_t idx, logic [VB-1:0] val);
        case (idx)
            REG_CTRL_MIN: c_min = val;
            REG_CTRL_MAX: c_max = val;
            REG_OUT_MIN:  o_min = val;
            REG_OUT_MAX:  o_max = val;
            REG_OVP_PCT:  pct = val[PCT_BITS-1:0];
            REG_SLEW:     slew = val;
            default: ;
        endcase
    endfunction

    function automatic logic [VB-1:0] rnd_volt();
        if ($urandom_range(0, 1) == 0) return VB'($urandom);
        return VB'($urandom_range(0, 2_000_000));
    endfunction

    function automatic void rnd_range(output logic [VB-1:0] lo, output logic [VB-1:0] hi);
        logic [VB-1:0] x, y;
        x = rnd_volt();
        y = rnd_volt();
        case ($urandom_range(0, 7))
            0: begin
                lo = x;
                hi = x;
            end
            1: begin
                lo = (x > y) ? x : y;
                hi = (x > y) ? y : x;
            end
            default: begin
                lo = (x < y) ? x : y;
                hi = (x < y) ? y : x;
            end
        endcase
    endfunction

    function automatic ramp_req_t rnd_ack();
        return '{KIND_ACK, VB'($urandom), VB'($urandom), VB'($urandom), 1'($urandom_range(0, 1))};
    endfunction

    function automatic ramp_req_t rnd_req();
        ramp_req_t     r;
        logic [VB-1:0] now, otop;
        otop = top_of(o_min, o_max);
        r.kind = KIND_REQ;
        r.ok = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0) r.rb = VB'($urandom);
        else r.rb = VB'($urandom_range(c_min, top_of(c_min, c_max)));
        now = out_of_ctrl(r.rb);
        case ($urandom_range(0, 7))
            0: r.rmin = VB'($urandom);
            1: r.rmin = VB'($urandom_range(now, otop));
            default: r.rmin = VB'($urandom_range(o_min, now));
        endcase
        if ($urandom_range(0, 4) == 0) r.rmax = VB'($urandom);
        else r.rmax = VB'($urandom_range(r.rmin, otop));
        return r;
    endfunction

    function automatic void row(ramp_req_t r);
        ramp_plan.push_back('{1'b0, REG_CTRL_MIN, '0, r, 1'b0, '0});
    endfunction

    function automatic void row_x(ramp_req_t r, ramp_cmd_t want);
        ramp_plan.push_back('{1'b0, REG_CTRL_MIN, '0, r, 1'b1, want});
    endfunction

    function automatic void row_cfg(cfg_idx_t idx, logic [VB-1:0] val);
        ramp_plan.push_back('{1'b1, idx, val, '0, 1'b0, '0});
    endfunction

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        dirty = 1'b0;
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [VB-1:0] val);
        if (dirty) settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        apply_reg(idx, val);
        n_cfg++;
    endtask

    task automatic send_item(ramp_req_t r, logic typed, ramp_cmd_t want);
        ramp_cmd_t res;
        int        gap;
        cfg_wr_en <= 1'b0;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= r.kind;
        s_tdata <= DW'({r.ok, r.rb, r.rmax, r.rmin});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (ramp_predict(r, res) || typed) pending_cmds.push_back(typed ? want : res);
        dirty = 1'b1;
    endtask

    task automatic pick_config(int setting);
        logic [VB-1:0] a, b, c, d, p, s;
        case (setting)
            0: begin
                a = '0; b = VMAX; c = '0; d = VMAX;
                p = VB'(100); s = VMAX;
            end
            1: begin
                a = '0; b = VB'(1000); c = '0; d = VMAX;
                p = VMAX; s = '0;
            end
            default: begin
                rnd_range(a, b);
                rnd_range(c, d);
                case ($urandom_range(0, 9))
                    0: p = '0;
                    1: p = VB'(100);
                    2: p = VB'($urandom_range(101, 127));
                    3: p = VB'(1);
                    default: p = VB'($urandom_range(2, 60));
                endcase
                if ($urandom_range(0, 3) == 0) p = p | (VB'($urandom) & ~VB'(7'h7f));
                case ($urandom_range(0, 5))
                    0: s = '0;
                    1: s = VB'(1);
                    2: s = VMAX;
                    3: s = VB'($urandom);
                    default: s = VB'($urandom_range(1, 5000));
                endcase
            end
        endcase
        write_reg(REG_CTRL_MIN, a);
        write_reg(REG_CTRL_MAX, b);
        write_reg(REG_OUT_MIN, c);
        write_reg(REG_OUT_MAX, d);
        write_reg(REG_OVP_PCT, p);
        write_reg(REG_SLEW, s);
    endtask

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(0, 15);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        ramp_cmd_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tuser, m_tdata[VB-1:0], m_tdata[2*VB-1:VB], m_tdata[3*VB-1:2*VB],
                    m_tdata[3*VB]};
            if (got.command == CMD_DRIVE) n_drive++;
            else if (got.status == STATUS_OK) n_done_ok++;
            else n_done_err++;
            if (pending_cmds.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result cmd %0d lo %0d hi %0d wait %0d st %0d",
                             $time, got.command, got.lo, got.hi, got.wait_us, got.status);
            end else begin
                want = pending_cmds.pop_front();
                if (got.command !== want.command || got.lo !== want.lo || got.hi !== want.hi
                    || got.wait_us !== want.wait_us || got.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: expected cmd %0d lo %0d hi %0d wait %0d st %0d",
                                 $time, want.command, want.lo, want.hi, want.wait_us,
                                 want.status);
                        $display("%0t:      got cmd %0d lo %0d hi %0d wait %0d st %0d",
                                 $time, got.command, got.lo, got.hi, got.wait_us, got.status);
                    end
                end
            end
        end
    end

    initial begin
        ramp_req_t rq;
        int        cap, acks, target, n_directed;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        row(mk_ack(1'b1));
        row_x(mk_req(VB'(100), VB'(200), '0), mk_cmd(CMD_DRIVE, VB'(100), VB'(200), '0, STATUS_OK));
        row(mk_req('0, '0, '0));
        row_x(mk_ack(1'b1), mk_cmd(CMD_DONE, '0, '0, '0, STATUS_OK));
        row_x(mk_req(VMAX, VMAX, VMAX),
              mk_cmd(CMD_DRIVE, VB'(1000000), VB'(1000000), '0, STATUS_OK));
        row_x(mk_ack(1'b0), mk_cmd(CMD_DONE, '0, '0, '0, STATUS_ERR));
        row_x(mk_req(VB'(500), VB'(100), '0), mk_cmd(CMD_DRIVE, VB'(500), VB'(100), '0, STATUS_OK));
        row_x(mk_ack(1'b1), mk_cmd(CMD_DONE, '0, '0, '0, STATUS_OK));
        row_cfg(REG_OVP_PCT, VB'(10));
        row_cfg(REG_SLEW, VB'(1000));
        row_x(mk_req('0, VMAX, VB'(1000000)),
              mk_cmd(CMD_DRIVE, VB'(900000), VB'(900000), VB'(100), STATUS_OK));
        row_x(mk_ack(1'b0), mk_cmd(CMD_DRIVE, VB'(1000000), VB'(1000000), '0, STATUS_OK));
        row_x(mk_ack(1'b1), mk_cmd(CMD_DONE, '0, '0, '0, STATUS_ERR));
        row_x(mk_req(VB'(999999), VB'(1000000), VB'(1000000)),
              mk_cmd(CMD_DRIVE, VB'(999999), VB'(999999), VB'(1), STATUS_OK));
        row_x(mk_ack(1'b1), mk_cmd(CMD_DONE, '0, '0, '0, STATUS_OK));
        row(mk_req('0, '0, VB'(1000000)));
        row(mk_ack(1'b1));
        row_x(mk_ack(1'b0), mk_cmd(CMD_DRIVE, VB'(1000000), VB'(1000000), '0, STATUS_OK));
        row_x(mk_ack(1'b0), mk_cmd(CMD_DONE, '0, '0, '0, STATUS_ERR));
        row_cfg(REG_OVP_PCT, VMAX);
        row_cfg(REG_SLEW, '0);
        row_x(mk_req(VB'(5000), VB'(5000), VB'(1000000)),
              mk_cmd(CMD_DRIVE, VB'(5000), VB'(5000), VB'(995000), STATUS_OK));
        row_x(mk_ack(1'b1), mk_cmd(CMD_DONE, '0, '0, '0, STATUS_OK));
        row_cfg(REG_OVP_PCT, VB'(1));
        row_x(mk_req('0, '0, VB'(50)), mk_cmd(CMD_DRIVE, VB'(49), VB'(49), VB'(1), STATUS_OK));
        row_x(mk_ack(1'b0), mk_cmd(CMD_DRIVE, VB'(50), VB'(50), '0, STATUS_OK));
        row_x(mk_ack(1'b1), mk_cmd(CMD_DONE, '0, '0, '0, STATUS_ERR));
        row_cfg(REG_CTRL_MIN, VB'(5000));
        row_cfg(REG_CTRL_MAX, VB'(5000));
        row_cfg(REG_OUT_MAX, VMAX);
        row_cfg(REG_OVP_PCT, VB'(50));
        row_cfg(REG_SLEW, VMAX);
        row(mk_req('0, VMAX, VB'(4999)));
        row(mk_ack(1'b1));
        row(mk_req('0, '0, VMAX));
        row(mk_ack(1'b0));
        row(mk_ack(1'b1));
        row_cfg(REG_CTRL_MIN, '0);
        row_cfg(REG_CTRL_MAX, VMAX);
        row_cfg(REG_OUT_MIN, VB'(7000));
        row_cfg(REG_OUT_MAX, VB'(7000));
        row(mk_req(VMAX, '0, VB'(123)));
        row(mk_ack(1'b1));

        n_directed = 0;
        foreach (ramp_plan[i]) begin
            if (ramp_plan[i].is_cfg) begin
                write_reg(ramp_plan[i].idx, ramp_plan[i].val);
            end else begin
                send_item(ramp_plan[i].req, ramp_plan[i].typed, ramp_plan[i].want);
                n_directed++;
            end
        end

        for (int setting = 0; setting < NUM_SETTINGS; setting++) begin
            pick_config(setting);
            idle_on = (setting == NUM_SETTINGS - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            target = (setting + 1) * RANDOM_ITEMS / NUM_SETTINGS;
            while (n_items < target) begin
                // stray acknowledge while idle
                if ($urandom_range(0, 9) == 0) send_item(rnd_ack(), 1'b0, '0);
                send_item(rnd_req(), 1'b0, '0);
                n_items++;
                cap = $urandom_range(4, 40);
                acks = 0;
                while (ph != PH_IDLE) begin
                    // request while busy
                    if ($urandom_range(0, 11) == 0) send_item(rnd_req(), 1'b0, '0);
                    rq = rnd_ack();
                    rq.ok = (acks >= cap) ? 1'b0 : 1'($urandom_range(0, 15) != 0);
                    send_item(rq, 1'b0, '0);
                    n_items++;
                    acks++;
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Ran %0d directed and %0d random requests over %0d register writes.",
                 n_directed, n_items, n_cfg);
        $display("Saw %0d drive commands, %0d clean finishes and %0d failed finishes.",
                 n_drive, n_done_ok, n_done_err);
        if (mismatches == 0) begin
            $display("PASS ovp_safe_voltage_ramp_linear_unit");
        end else begin
            $display("FAIL ovp_safe_voltage_ramp_linear_unit");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ovpr_pkg.sv
sv/ovpr_muldiv.sv
sv/ovp_safe_voltage_ramp_linear_unit.sv
tb/tb_ovp_safe_voltage_ramp_linear_unit.sv
